// ----- hdl/slba_pkg.sv -----
package slba_pkg;

    localparam int MAX_MACHINES_DEF = 16;

    localparam int CFG_W   = 5;
    localparam int MEAN_W  = 16;
    localparam int VAR_W   = 16;
    localparam int MACH_W  = 4;
    localparam int JOBS_W  = 5;
    localparam int TOTAL_W = 20;
    // n * mean_sum fits in 21 bits, so |a| does too
    localparam int MAG_W   = 21;
    localparam int A_W     = MAG_W + 1;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int HALF_W  = MAG_W;
    localparam int PART_W  = HALF_W + VAR_W;
    localparam int PROD_W  = SQ_W + VAR_W;
    localparam int WORD_W  = MEAN_W + VAR_W;

    localparam logic REQ_FIRST = 1'b0;
    localparam logic REQ_NEXT  = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [MEAN_W-1:0] job_mean;
        logic [VAR_W-1:0]  job_var;
    } in_t;

    typedef struct packed {
        logic [MACH_W-1:0] machine;
        logic              saturated;
    } out_t;

    typedef struct packed {
        logic load;
        logic order_pick;
        logic scan_start;
        logic stage_a;
        logic scan_cmp;
        logic scan_next;
        logic upd_write;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic in_order;
        logic scan_last;
    } sts_t;

endpackage

// ----- hdl/slba_ctrl.sv -----
module slba_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    output logic            m_valid,
    input  logic            m_ready,
    input  slba_pkg::sts_t  sts,
    output slba_pkg::cmd_t  cmd
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_CHK  = 4'd1;
    localparam logic [3:0] ST_SA   = 4'd2;
    localparam logic [3:0] ST_SSQ  = 4'd3;
    localparam logic [3:0] ST_SP   = 4'd4;
    localparam logic [3:0] ST_SCMP = 4'd5;
    localparam logic [3:0] ST_URD  = 4'd6;
    localparam logic [3:0] ST_UWR  = 4'd7;
    localparam logic [3:0] ST_OUT  = 4'd8;

    logic [3:0] state_reg, state_next;
    logic       m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHK;
                end
            end
            ST_CHK: begin
                if (sts.in_order) begin
                    cmd.order_pick = 1'b1;
                    state_next     = ST_URD;
                end else begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SA;
                end
            end
            ST_SA: begin
                cmd.stage_a = 1'b1;
                state_next  = ST_SSQ;
            end
            ST_SSQ: state_next = ST_SP;
            ST_SP:  state_next = ST_SCMP;
            ST_SCMP: begin
                cmd.scan_cmp = 1'b1;
                if (sts.scan_last) begin
                    state_next = ST_URD;
                end else begin
                    // fetch the next machine while this one is judged
                    cmd.scan_next = 1'b1;
                    state_next    = ST_SA;
                end
            end
            ST_URD: state_next = ST_UWR;
            ST_UWR: begin
                cmd.upd_write = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- hdl/slba_dp.sv -----
module slba_dp #(
    parameter int MAX_MACHINES = slba_pkg::MAX_MACHINES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [slba_pkg::CFG_W-1:0] cfg_wdata,
    input  slba_pkg::in_t              s_data,
    input  slba_pkg::cmd_t             cmd,
    output slba_pkg::sts_t             sts,
    output slba_pkg::out_t             m_data
);

    localparam int IDX_W = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;

    logic [slba_pkg::CFG_W-1:0]   num_reg;
    logic [slba_pkg::CFG_W-1:0]   n_eff;
    logic [slba_pkg::MEAN_W-1:0]  job_mean_reg;
    logic [slba_pkg::VAR_W-1:0]   job_var_reg;
    logic [slba_pkg::TOTAL_W-1:0] total_reg;
    logic [slba_pkg::JOBS_W-1:0]  jobs_reg;
    logic [slba_pkg::MACH_W-1:0]  last_reg;

    logic [slba_pkg::WORD_W-1:0]  mem [MAX_MACHINES];
    logic [MAX_MACHINES-1:0]      vld_reg;
    logic [slba_pkg::WORD_W-1:0]  rd_word_reg;
    logic                         rd_vld_reg;
    logic [IDX_W-1:0]             rd_addr;
    logic [slba_pkg::MEAN_W-1:0]  mean_rd;
    logic [slba_pkg::VAR_W-1:0]   var_rd;

    logic [IDX_W-1:0]             idx_reg;
    logic [IDX_W-1:0]             pick_reg;

    logic [slba_pkg::MAG_W-1:0]   nm;
    logic signed [slba_pkg::A_W-1:0] a_val;
    logic [slba_pkg::MAG_W-1:0]   mag;
    logic                         a_neg_reg;
    logic [slba_pkg::MAG_W-1:0]   mag_reg;
    logic [slba_pkg::VAR_W-1:0]   v_reg;
    logic [slba_pkg::SQ_W-1:0]    sq_reg;
    logic [slba_pkg::PART_W-1:0]  l_lo_reg, l_hi_reg, r_lo_reg, r_hi_reg;
    logic [slba_pkg::PROD_W-1:0]  l_prod, r_prod;

    logic                         have_reg, ninf_reg, best_neg_reg;
    logic [slba_pkg::SQ_W-1:0]    best_sq_reg;
    logic [slba_pkg::VAR_W-1:0]   best_v_reg;
    logic                         less, take, take_ninf;

    logic [slba_pkg::MEAN_W:0]    mean_sum;
    logic [slba_pkg::VAR_W:0]     var_sum;
    logic [slba_pkg::TOTAL_W:0]   total_sum;
    logic [slba_pkg::MEAN_W-1:0]  mean_new;
    logic [slba_pkg::VAR_W-1:0]   var_new;
    logic [slba_pkg::TOTAL_W-1:0] total_new;
    logic                         sat;

    slba_pkg::out_t               res_reg;
    slba_pkg::out_t               out_reg;

    assign m_data = out_reg;

    always_comb begin
        if (num_reg == '0) begin
            n_eff = slba_pkg::CFG_W'(1);
        end else if (32'(num_reg) > MAX_MACHINES) begin
            n_eff = slba_pkg::CFG_W'(MAX_MACHINES);
        end else begin
            n_eff = num_reg;
        end
    end

    assign sts.in_order  = (jobs_reg < slba_pkg::JOBS_W'(n_eff));
    assign sts.scan_last = ((32'(idx_reg) + 32'd1) == 32'(n_eff));

    always_comb begin
        if (cmd.scan_start) begin
            rd_addr = '0;
        end else if (cmd.scan_next) begin
            rd_addr = idx_reg + IDX_W'(1);
        end else begin
            rd_addr = pick_reg;
        end
    end

    // never-written entries read as zero
    assign mean_rd = rd_vld_reg ? rd_word_reg[slba_pkg::WORD_W-1:slba_pkg::VAR_W] : '0;
    assign var_rd  = rd_vld_reg ? rd_word_reg[slba_pkg::VAR_W-1:0] : '0;

    // a = n * mean_sum - total_mean
    always_comb begin
        nm    = slba_pkg::MAG_W'(n_eff) * slba_pkg::MAG_W'(mean_rd);
        a_val = $signed({1'b0, nm}) - $signed({2'b00, total_reg});
        if (a_val[slba_pkg::A_W-1]) begin
            mag = slba_pkg::MAG_W'(-a_val);
        end else begin
            mag = slba_pkg::MAG_W'(a_val);
        end
    end

    // cross products a^2 * v_best and a_best^2 * v, split at HALF_W
    always_comb begin
        l_prod = (slba_pkg::PROD_W'(l_hi_reg) << slba_pkg::HALF_W)
               + slba_pkg::PROD_W'(l_lo_reg);
        r_prod = (slba_pkg::PROD_W'(r_hi_reg) << slba_pkg::HALF_W)
               + slba_pkg::PROD_W'(r_lo_reg);
        if (a_neg_reg && !best_neg_reg) begin
            less = 1'b1;
        end else if (!a_neg_reg && best_neg_reg) begin
            less = 1'b0;
        end else if (a_neg_reg) begin
            less = (l_prod > r_prod);
        end else begin
            less = (l_prod < r_prod);
        end
        take_ninf = 1'b0;
        if (v_reg == '0) begin
            take      = a_neg_reg && !ninf_reg;
            take_ninf = take;
        end else if (!have_reg) begin
            take = 1'b1;
        end else begin
            take = !ninf_reg && less;
        end
    end

    always_comb begin
        mean_sum  = {1'b0, mean_rd} + {1'b0, job_mean_reg};
        var_sum   = {1'b0, var_rd} + {1'b0, job_var_reg};
        total_sum = {1'b0, total_reg} + (slba_pkg::TOTAL_W+1)'(job_mean_reg);
        mean_new  = mean_sum[slba_pkg::MEAN_W] ? '1 : mean_sum[slba_pkg::MEAN_W-1:0];
        var_new   = var_sum[slba_pkg::VAR_W] ? '1 : var_sum[slba_pkg::VAR_W-1:0];
        total_new = total_sum[slba_pkg::TOTAL_W] ? '1 : total_sum[slba_pkg::TOTAL_W-1:0];
        sat       = mean_sum[slba_pkg::MEAN_W] | var_sum[slba_pkg::VAR_W]
                  | total_sum[slba_pkg::TOTAL_W];
    end

    // sum memory
    always_ff @(posedge aclk) begin
        if (cmd.upd_write) begin
            mem[pick_reg] <= {mean_new, var_new};
        end
        rd_word_reg <= mem[rd_addr];
        rd_vld_reg  <= vld_reg[rd_addr];
    end

    // datapath payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            job_mean_reg <= s_data.job_mean;
            job_var_reg  <= s_data.job_var;
        end
        if (cmd.stage_a) begin
            a_neg_reg <= a_val[slba_pkg::A_W-1];
            mag_reg   <= mag;
            v_reg     <= var_rd;
        end
        sq_reg   <= slba_pkg::SQ_W'(mag_reg) * slba_pkg::SQ_W'(mag_reg);
        l_lo_reg <= slba_pkg::PART_W'(sq_reg[slba_pkg::HALF_W-1:0])
                  * slba_pkg::PART_W'(best_v_reg);
        l_hi_reg <= slba_pkg::PART_W'(sq_reg[slba_pkg::SQ_W-1:slba_pkg::HALF_W])
                  * slba_pkg::PART_W'(best_v_reg);
        r_lo_reg <= slba_pkg::PART_W'(best_sq_reg[slba_pkg::HALF_W-1:0])
                  * slba_pkg::PART_W'(v_reg);
        r_hi_reg <= slba_pkg::PART_W'(best_sq_reg[slba_pkg::SQ_W-1:slba_pkg::HALF_W])
                  * slba_pkg::PART_W'(v_reg);
        if (cmd.scan_cmp && take) begin
            best_neg_reg <= a_neg_reg;
            best_sq_reg  <= sq_reg;
            best_v_reg   <= v_reg;
        end
        if (cmd.upd_write) begin
            res_reg.machine   <= slba_pkg::MACH_W'(pick_reg);
            res_reg.saturated <= sat;
        end
        if (cmd.out_load) begin
            out_reg <= res_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_reg   <= slba_pkg::CFG_W'(1);
            total_reg <= '0;
            jobs_reg  <= '0;
            last_reg  <= '0;
            vld_reg   <= '0;
            idx_reg   <= '0;
            pick_reg  <= '0;
            have_reg  <= 1'b0;
            ninf_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                num_reg <= cfg_wdata;
            end
            if (cmd.load && (s_data.req_type == slba_pkg::REQ_FIRST)) begin
                total_reg <= '0;
                jobs_reg  <= '0;
                last_reg  <= '0;
                vld_reg   <= '0;
            end
            if (cmd.order_pick) begin
                pick_reg <= IDX_W'(jobs_reg);
                jobs_reg <= jobs_reg + slba_pkg::JOBS_W'(1);
            end
            if (cmd.scan_start) begin
                idx_reg  <= '0;
                have_reg <= 1'b0;
                ninf_reg <= 1'b0;
                pick_reg <= IDX_W'(last_reg);
            end
            if (cmd.scan_cmp) begin
                if (take) begin
                    have_reg <= 1'b1;
                    pick_reg <= idx_reg;
                end
                if (take_ninf) begin
                    ninf_reg <= 1'b1;
                end
                if (sts.scan_last) begin
                    last_reg <= take ? slba_pkg::MACH_W'(idx_reg)
                                     : slba_pkg::MACH_W'(pick_reg);
                end
            end
            if (cmd.scan_next) begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (cmd.upd_write) begin
                vld_reg[pick_reg] <= 1'b1;
                total_reg         <= total_new;
            end
        end
    end

endmodule

// ----- hdl/stochastic_load_balance_assign_core.sv -----
// Sequence: an in-order job goes from accept through check, sum read, sum write and output
// states to m_valid; a job that scans n machines runs, per machine, a = n*mean - total,
// square, split cross products and compare (the next machine's sums are read during the
// compare). The output state waits while the previous word is unread. One job at a time;
// the result register lets the next job enter while the previous word waits.
// Reset (aresetn low, synchronous): sums (via their valid bits), counters and scan flags cleared, num_machines = 1.
module stochastic_load_balance_assign_core #(
    parameter int MAX_MACHINES = slba_pkg::MAX_MACHINES_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [slba_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  slba_pkg::in_t              s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output slba_pkg::out_t             m_data
);

    slba_pkg::cmd_t cmd;
    slba_pkg::sts_t sts;

    slba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    slba_dp #(
        .MAX_MACHINES (MAX_MACHINES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .sts       (sts),
        .m_data    (m_data)
    );

endmodule

// ----- bench/tb_stochastic_load_balance_assign_core.sv -----
`timescale 1ns / 1ps

module tb_stochastic_load_balance_assign_core;

    localparam int MAX_MACH     = slba_pkg::MAX_MACHINES_DEF;
    localparam int RAND_JOBS    = 1600;
    localparam int DRAIN_PAD    = 80;     // longer than a full 16-machine scan
    localparam int HOLD_CYCLES  = 400;
    localparam int STALL_LIMIT  = 4000;
    localparam int N_DIR        = 27;
    localparam int MEAN_MAX     = 65535;
    localparam int TOTAL_MAX    = 1048575;

    typedef struct packed {
        bit                          cfg_row;
        logic [slba_pkg::CFG_W-1:0]  cfg_val;
        logic                        req;
        logic [slba_pkg::MEAN_W-1:0] mean;
        logic [slba_pkg::VAR_W-1:0]  variance;
        bit                          typed;
        slba_pkg::out_t              want;
    } dir_row_t;

    logic aclk;
    logic aresetn;
    logic cfg_we;
    logic [slba_pkg::CFG_W-1:0] cfg_wdata;
    logic s_valid;
    logic s_ready;
    slba_pkg::in_t  s_data;
    logic m_valid;
    logic m_ready;
    slba_pkg::out_t m_data;

    // predictor state
    logic [slba_pkg::CFG_W-1:0]   mach_cfg;
    logic [slba_pkg::MEAN_W-1:0]  mean_acc [MAX_MACH];
    logic [slba_pkg::VAR_W-1:0]   var_acc [MAX_MACH];
    logic [slba_pkg::TOTAL_W-1:0] total_acc;
    logic [slba_pkg::JOBS_W-1:0]  jobs_cnt;
    logic [slba_pkg::MACH_W-1:0]  last_pick;

    slba_pkg::out_t pending_picks [$];
    int   mism_count;

    bit   want_typed;
    slba_pkg::out_t want_val;
    bit   gaps_on;
    int   burst_left;
    bit   hold_req;

    dir_row_t dir_rows [0:N_DIR-1];

    stochastic_load_balance_assign_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    function automatic void clear_sums();
        for (int i = 0; i < MAX_MACH; i++) begin
            mean_acc[i] = '0;
            var_acc[i]  = '0;
        end
        total_acc = '0;
        jobs_cnt  = '0;
        last_pick = '0;
    endfunction

    // a1/sqrt(v1) < a2/sqrt(v2), both variances nonzero
    function automatic bit rho_below(longint a1, longint unsigned v1,
                                     longint a2, longint unsigned v2);
        longint unsigned m1, m2, l, r;
        if (a1 < 0 && a2 >= 0) return 1'b1;
        if (a1 >= 0 && a2 < 0) return 1'b0;
        m1 = (a1 < 0) ? -a1 : a1;
        m2 = (a2 < 0) ? -a2 : a2;
        l = m1 * m1 * v2;
        r = m2 * m2 * v1;
        return (a1 >= 0) ? (l < r) : (l > r);
    endfunction

    function automatic slba_pkg::out_t pick_machine(slba_pkg::in_t job);
        int unsigned n, pick, acc;
        bit clip, have, best_neg_inf;
        longint a, best_a;
        longint unsigned best_v;
        slba_pkg::out_t res;
        n = (mach_cfg == 0) ? 1 : ((mach_cfg > MAX_MACH) ? MAX_MACH : mach_cfg);
        clip = 1'b0;
        if (job.req_type == slba_pkg::REQ_FIRST) clear_sums();
        if (jobs_cnt < n) begin
            pick = jobs_cnt;
            jobs_cnt = jobs_cnt + 1'b1;
        end else begin
            have = 1'b0;
            best_neg_inf = 1'b0;
            best_a = 0;
            best_v = 0;
            pick = last_pick;
            for (int i = 0; i < n; i++) begin
                a = longint'(n) * longint'(mean_acc[i]) - longint'(total_acc);
                if (var_acc[i] == 0) begin
                    // empty variance: negative offset wins outright, else never chosen
                    if (a < 0 && !best_neg_inf) begin
                        have = 1'b1;
                        best_neg_inf = 1'b1;
                        pick = i;
                    end
                end else if (!have) begin
                    have = 1'b1;
                    best_a = a;
                    best_v = var_acc[i];
                    pick = i;
                end else if (!best_neg_inf &&
                             rho_below(a, var_acc[i], best_a, best_v)) begin
                    best_a = a;
                    best_v = var_acc[i];
                    pick = i;
                end
            end
            last_pick = pick[slba_pkg::MACH_W-1:0];
        end
        acc = mean_acc[pick] + job.job_mean;
        if (acc > MEAN_MAX) begin
            clip = 1'b1;
            acc = MEAN_MAX;
        end
        mean_acc[pick] = acc[slba_pkg::MEAN_W-1:0];
        acc = var_acc[pick] + job.job_var;
        if (acc > MEAN_MAX) begin
            clip = 1'b1;
            acc = MEAN_MAX;
        end
        var_acc[pick] = acc[slba_pkg::VAR_W-1:0];
        acc = total_acc + job.job_mean;
        if (acc > TOTAL_MAX) begin
            clip = 1'b1;
            acc = TOTAL_MAX;
        end
        total_acc = acc[slba_pkg::TOTAL_W-1:0];
        res.machine   = pick[slba_pkg::MACH_W-1:0];
        res.saturated = clip;
        return res;
    endfunction

    function automatic logic [15:0] draw_value(int zero_wt);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < zero_wt) return 16'h0000;
        if (sel == zero_wt) return 16'hFFFF;
        if (sel < zero_wt + 3) return 16'($urandom_range(0, 15));
        return 16'($urandom);
    endfunction

    function automatic slba_pkg::in_t make_job(logic req);
        slba_pkg::in_t job;
        job.req_type = req;
        job.job_mean = draw_value(1);
        job.job_var  = draw_value(3);
        return job;
    endfunction

    // scoreboard: check the outgoing word first, then predict the incoming one
    always @(posedge aclk) begin
        slba_pkg::out_t exp_word;
        if (!aresetn) begin
            mach_cfg = 5'd1;
            clear_sums();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_picks.size() == 0) begin
                    if (mism_count < 10)
                        $display("unexpected result word: machine %0d saturated %0b",
                                 m_data.machine, m_data.saturated);
                    mism_count++;
                end else begin
                    exp_word = pending_picks.pop_front();
                    if (m_data.machine !== exp_word.machine ||
                        m_data.saturated !== exp_word.saturated) begin
                        if (mism_count < 10)
                            $display({"mismatch at %0t: expected machine %0d sat %0b,",
                                      " got %0d sat %0b"},
                                     $realtime, exp_word.machine, exp_word.saturated,
                                     m_data.machine, m_data.saturated);
                        mism_count++;
                    end
                end
            end
            if (cfg_we)
                mach_cfg = cfg_wdata;
            if (s_valid && s_ready) begin
                exp_word = pick_machine(s_data);
                if (want_typed)
                    exp_word = want_val;
                pending_picks = {pending_picks, exp_word};
            end
        end
    end

    // receiver: its own stall pattern, plus one long hold-off on request
    initial begin
        int mode, mode_left, tick, period, low_len;
        bit held;
        m_ready = 1'b0;
        mode_left = 0;
        tick = 0;
        period = 1;
        low_len = 0;
        mode = 0;
        held = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req && !held) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                held = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(50, 400);
                    period = $urandom_range(2, 17);
                    low_len = $urandom_range(1, period - 1);
                end
                mode_left--;
                tick++;
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= ($urandom_range(0, 3) != 0);
                    default: m_ready <= ((tick % period) >= low_len);
                endcase
            end
        end
    end

    // watchdog: end the run when nothing moves for too long
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("stochastic_load_balance_assign_core regression: fail");
        $finish;
    end

    task automatic send_job(input slba_pkg::in_t job, input bit typed,
                            input slba_pkg::out_t want);
        int gap;
        gap = 0;
        if (gaps_on && burst_left == 0) begin
            gap = $urandom_range(1, 10);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0) burst_left--;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        want_typed = typed;
        want_val = want;
        s_valid <= 1'b1;
        s_data <= job;
        do @(posedge aclk); while (!s_ready);
    endtask

    // drop valid and wait until every pending word has come back
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_picks.size() != 0) @(posedge aclk);
        repeat (DRAIN_PAD) @(posedge aclk);
    endtask

    task automatic write_cfg(input logic [slba_pkg::CFG_W-1:0] value);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        slba_pkg::in_t job;
        int rnd_sent, phase, phase_jobs, sent_here, span;
        logic head;
        bit hold_done;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_valid = 1'b0;
        s_data = '0;
        hold_req = 1'b0;
        want_typed = 1'b0;
        want_val = '0;
        gaps_on = 1'b1;
        burst_left = 0;
        mism_count = 0;
        hold_done = 1'b0;

        dir_rows = '{
            // after reset: count is 1, next job without an instance
            '{1'b0, 5'd0, slba_pkg::REQ_NEXT,  16'h0000, 16'h0000, 1'b1, '{4'd0, 1'b0}},
            '{1'b0, 5'd0, slba_pkg::REQ_FIRST, 16'hFFFF, 16'hFFFF, 1'b1, '{4'd0, 1'b0}},
            '{1'b0, 5'd0, slba_pkg::REQ_NEXT,  16'h0001, 16'h0001, 1'b1, '{4'd0, 1'b1}},
            '{1'b0, 5'd0, slba_pkg::REQ_NEXT,  16'h0000, 16'h0000, 1'b1, '{4'd0, 1'b0}},
            // count of zero acts as one
            '{1'b1, 5'd0, slba_pkg::REQ_FIRST, 16'h0000, 16'h0000, 1'b0, '{4'd0, 1'b0}},
            '{1'b0, 5'd0, slba_pkg::REQ_FIRST, 16'h0007, 16'h0003, 1'b1, '{4'd0, 1'b0}},
            '{1'b0, 5'd0, slba_pkg::REQ_NEXT,  16'h0002, 16'h0000, 1'b0, '{4'd0, 1'b0}},
            // zero variance: none qualifies, then a negative offset wins
            '{1'b1, 5'd2, slba_pkg::REQ_FIRST, 16'h0000, 16'h0000, 1'b0, '{4'd0, 1'b0}},
            '{1'b0, 5'd0, slba_pkg::REQ_FIRST, 16'h0000, 16'h0000, 1'b0, '{4'd0, 1'b0}},
            '{1'b0, 5'd0, slba_pkg::REQ_NEXT,  16'h0000, 16'h0000, 1'b0, '{4'd0, 1'b0}},
            '{1'b0, 5'd0, slba_pkg::REQ_NEXT,  16'h0000, 16'h0000, 1'b0, '{4'd0, 1'b0}},
            '{1'b0, 5'd0, slba_pkg::REQ_NEXT,  16'h0005, 16'h0000, 1'b0, '{4'd0, 1'b0}},
            '{1'b0, 5'd0, slba_pkg::REQ_NEXT,  16'h0001, 16'h0000, 1'b0, '{4'd0, 1'b0}},
            // tie goes to the lowest index
            '{1'b0, 5'd0, slba_pkg::REQ_FIRST, 16'h0004, 16'h0001, 1'b0, '{4'd0, 1'b0}},
            '{1'b0, 5'd0, slba_pkg::REQ_NEXT,  16'h0004, 16'h0001, 1'b0, '{4'd0, 1'b0}},
            '{1'b0, 5'd0, slba_pkg::REQ_NEXT,  16'h0009, 16'h0002, 1'b0, '{4'd0, 1'b0}},
            // count raised mid-instance reopens the in-order phase
            '{1'b1, 5'd3, slba_pkg::REQ_FIRST, 16'h0000, 16'h0000, 1'b0, '{4'd0, 1'b0}},
            '{1'b0, 5'd0, slba_pkg::REQ_NEXT,  16'h0001, 16'h0001, 1'b0, '{4'd0, 1'b0}},
            // count above the machine limit
            '{1'b1, 5'd31, slba_pkg::REQ_FIRST, 16'h0000, 16'h0000, 1'b0, '{4'd0, 1'b0}},
            '{1'b0, 5'd0, slba_pkg::REQ_FIRST, 16'h8000, 16'h0001, 1'b0, '{4'd0, 1'b0}},
            '{1'b0, 5'd0, slba_pkg::REQ_NEXT,  16'hFFFF, 16'h0000, 1'b0, '{4'd0, 1'b0}},
            '{1'b0, 5'd0, slba_pkg::REQ_NEXT,  16'h0000, 16'hFFFF, 1'b0, '{4'd0, 1'b0}},
            '{1'b1, 5'd16, slba_pkg::REQ_FIRST, 16'h0000, 16'h0000, 1'b0, '{4'd0, 1'b0}},
            '{1'b0, 5'd0, slba_pkg::REQ_FIRST, 16'hFFFF, 16'h0000, 1'b0, '{4'd0, 1'b0}},
            '{1'b0, 5'd0, slba_pkg::REQ_NEXT,  16'h0000, 16'hFFFF, 1'b0, '{4'd0, 1'b0}},
            // count lowered mid-instance: scan at once
            '{1'b1, 5'd1, slba_pkg::REQ_FIRST, 16'h0000, 16'h0000, 1'b0, '{4'd0, 1'b0}},
            '{1'b0, 5'd0, slba_pkg::REQ_NEXT,  16'h0001, 16'h0001, 1'b0, '{4'd0, 1'b0}}
        };

        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int r = 0; r < N_DIR; r++) begin
            if (dir_rows[r].cfg_row) begin
                settle();
                write_cfg(dir_rows[r].cfg_val);
            end else begin
                job.req_type = dir_rows[r].req;
                job.job_mean = dir_rows[r].mean;
                job.job_var  = dir_rows[r].variance;
                send_job(job, dir_rows[r].typed, dir_rows[r].want);
            end
        end

        rnd_sent = 0;
        phase = 0;
        while (rnd_sent < RAND_JOBS) begin
            settle();
            case (phase)
                0: write_cfg(5'd31);
                1: write_cfg(5'd16);
                2: write_cfg(5'd0);
                3: write_cfg(5'd1);
                default: begin
                    if ($urandom_range(0, 1) == 0)
                        write_cfg(5'($urandom_range(1, 4)));
                    else
                        write_cfg(5'($urandom_range(0, 31)));
                end
            endcase
            // the hold-off phase runs without sender gaps so the block backs up
            gaps_on = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            burst_left = 0;
            phase_jobs = $urandom_range(60, 200);
            if (phase_jobs > RAND_JOBS - rnd_sent)
                phase_jobs = RAND_JOBS - rnd_sent;
            sent_here = 0;
            while (sent_here < phase_jobs) begin
                head = ($urandom_range(0, 19) == 0) ? slba_pkg::REQ_NEXT
                                                    : slba_pkg::REQ_FIRST;
                span = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 48)
                                                    : $urandom_range(0, 20);
                for (int k = 0; k <= span && sent_here < phase_jobs; k++) begin
                    send_job(make_job((k == 0) ? head : slba_pkg::REQ_NEXT), 1'b0, '0);
                    sent_here++;
                    if (phase == 1 && !hold_done && sent_here > 30) begin
                        hold_req = 1'b1;
                        hold_done = 1'b1;
                    end
                end
            end
            rnd_sent += sent_here;
            phase++;
        end

        settle();
        if (mism_count == 0 && pending_picks.size() == 0)
            $display("stochastic_load_balance_assign_core regression: pass");
        else
            $display("stochastic_load_balance_assign_core regression: fail");
        $finish;
    end

endmodule
